// ===== hdl/pbod_pkg.sv =====
// Package for the pairwise bond order detector.
// Holds field widths, the atom, job and result word types, and the back end state codes.
// Used by every module of the block but pbod_fifo.
package pbod_pkg;

  localparam int POS_W  = 24;
  localparam int RAD_W  = 16;
  localparam int TOL_W  = 12;
  localparam int IDX_W  = 6;
  localparam int ORD_W  = 2;
  localparam int DIFF_W = POS_W + 1;
  localparam int THR_W  = RAD_W + 2;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int TSQ_W  = 2 * THR_W;
  localparam int TSQ_SHIFT = 8;

  localparam logic [TOL_W-1:0] TOL_RESET = 12'd328;

  localparam int JOB_DEPTH    = 2;
  localparam int JOB_CNT_W    = $clog2(JOB_DEPTH + 1);
  localparam int OUT_DEPTH    = 16;
  localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);
  localparam int PIPE_LAT     = 5;
  localparam int CREDIT_LIMIT = OUT_DEPTH - PIPE_LAT - 2;

  typedef enum logic [ORD_W-1:0] {
    ORD_NONE,
    ORD_SINGLE,
    ORD_DOUBLE,
    ORD_TRIPLE
  } order_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  typedef struct packed {
    logic [2:0][POS_W-1:0] pos;
    logic [2:0][RAD_W-1:0] rad;
  } atom_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    atom_t            atom;
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0] earlier;
    logic [IDX_W-1:0] newer;
    logic [ORD_W-1:0] order;
    logic             last;
  } result_t;

endpackage

// ===== hdl/pbod_fifo.sv =====
// Small first-in first-out queue of flip-flops with an occupancy count.
// Used for the job queue and the result queue; DEPTH must be a power of two.
// Depends on nothing else.
module pbod_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign count_o = count_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/pbod_front.sv =====
// Front end of the bond detector: accepts atom words, keeps the atom count.
// Assigns each atom its index, drops atoms beyond capacity and queues jobs.
// Depends on pbod_pkg.
module pbod_front #(
  parameter int MAX_ATOMS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          first_atom_i,
  input  logic signed [pbod_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [pbod_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [pbod_pkg::POS_W-1:0] pos_z_i,
  input  logic [pbod_pkg::RAD_W-1:0]    radius_single_i,
  input  logic [pbod_pkg::RAD_W-1:0]    radius_double_i,
  input  logic [pbod_pkg::RAD_W-1:0]    radius_triple_i,
  input  logic                          job_full_i,
  output logic                          job_push_o,
  output pbod_pkg::job_t                job_o
);

  import pbod_pkg::*;

  localparam int CW = $clog2(MAX_ATOMS + 1);

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] base;
  logic          accept;
  logic          room;

  assign in_stall_o = job_full_i;
  assign accept     = in_valid_i && !job_full_i;
  assign base       = first_atom_i ? '0 : count_q;
  assign room       = (base < CW'(MAX_ATOMS));
  assign job_push_o = accept && room;

  always_comb begin
    count_d = count_q;
    if (accept) begin
      count_d = room ? base + CW'(1) : base;
    end
  end

  always_comb begin
    job_o.idx          = IDX_W'(base);
    job_o.atom.pos[0]  = pos_x_i;
    job_o.atom.pos[1]  = pos_y_i;
    job_o.atom.pos[2]  = pos_z_i;
    job_o.atom.rad[0]  = radius_single_i;
    job_o.atom.rad[1]  = radius_double_i;
    job_o.atom.rad[2]  = radius_triple_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ===== hdl/pbod_back.sv =====
// Back end of the bond detector: atom memory, compare sequencer and distance pipeline.
// Holds back each bond one step so that the last one of an atom can be marked.
// Depends on pbod_pkg.
module pbod_back #(
  parameter int MAX_ATOMS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_empty_i,
  input  pbod_pkg::job_t                 job_i,
  output logic                           job_pop_o,
  input  logic [pbod_pkg::TOL_W-1:0]     tolerance_i,
  input  logic [pbod_pkg::OUT_CNT_W-1:0] out_count_i,
  output logic                           res_push_o,
  output pbod_pkg::result_t              res_o
);

  import pbod_pkg::*;

  localparam int AW = $clog2(MAX_ATOMS);

  back_state_e state_q, state_d;
  logic [AW-1:0] cmp_q;
  logic          issue;
  logic          is_last_cmp;
  logic          credit_ok;

  atom_t         mem_q [MAX_ATOMS];
  atom_t         rd_row_q;
  job_t          job_q;

  logic          s1_v_q, s1_last_q;
  logic [AW-1:0] s1_earlier_q;

  logic [DIFF_W-1:0] s1_diff [3];
  logic [DIFF_W-1:0] s1_abs  [3];
  logic [THR_W-1:0]  s1_thr  [3];
  logic [2:0]        s1_en;

  logic              s2_v_q, s2_last_q;
  logic [AW-1:0]     s2_earlier_q;
  logic [IDX_W-1:0]  s2_newer_q;
  logic [DIFF_W-1:0] s2_abs_q [3];
  logic [THR_W-1:0]  s2_thr_q [3];
  logic [2:0]        s2_en_q;

  logic              s3_v_q, s3_last_q;
  logic [AW-1:0]     s3_earlier_q;
  logic [IDX_W-1:0]  s3_newer_q;
  logic [SQ_W-1:0]   s3_sq_q  [3];
  logic [TSQ_W-1:0]  s3_tsq_q [3];
  logic [2:0]        s3_en_q;

  logic              s4_v_q, s4_last_q;
  logic [AW-1:0]     s4_earlier_q;
  logic [IDX_W-1:0]  s4_newer_q;
  logic [SUM_W-1:0]  s4_sum_q;
  logic [TSQ_W-1:0]  s4_tsq_q [3];
  logic [2:0]        s4_en_q;

  logic [2:0]        s4_within;
  order_e            s5_order_d, s5_order_q;
  logic              s5_v_q, s5_last_q;
  logic [AW-1:0]     s5_earlier_q;
  logic [IDX_W-1:0]  s5_newer_q;

  logic              bonded;
  logic              pend_v_q, pend_v_d;
  logic              pend_load;
  logic              flush_q, flush_d;
  logic [IDX_W-1:0]  pend_earlier_q;
  logic [IDX_W-1:0]  pend_newer_q;
  logic [ORD_W-1:0]  pend_order_q;
  logic              res_last;

  // Sequencer.
  assign credit_ok   = (out_count_i <= OUT_CNT_W'(CREDIT_LIMIT));
  assign is_last_cmp = (cmp_q == job_q.idx[AW-1:0] - AW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!job_empty_i && (job_i.idx != '0)) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (issue && is_last_cmp) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = 1'b0;
    issue     = 1'b0;
    case (state_q)
      BK_IDLE: job_pop_o = !job_empty_i;
      BK_RUN:  issue     = credit_ok;
      default: begin
        job_pop_o = 1'b0;
        issue     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cmp_q   <= '0;
    end else begin
      state_q <= state_d;
      if (job_pop_o) begin
        cmp_q <= '0;
      end else if (issue) begin
        cmp_q <= cmp_q + AW'(1);
      end
    end
  end

  // The new atom is stored when its job starts; its own compares never read its entry.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      mem_q[job_i.idx[AW-1:0]] <= job_i.atom;
      job_q                    <= job_i;
    end
    if (issue) begin
      rd_row_q <= mem_q[cmp_q];
    end
  end

  // Stage one: coordinate differences and radius sums.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s1_diff[k] = {rd_row_q.pos[k][POS_W-1], rd_row_q.pos[k]}
                 - {job_q.atom.pos[k][POS_W-1], job_q.atom.pos[k]};
      s1_abs[k]  = s1_diff[k][DIFF_W-1] ? (~s1_diff[k] + DIFF_W'(1)) : s1_diff[k];
      s1_thr[k]  = THR_W'(rd_row_q.rad[k]) + THR_W'(job_q.atom.rad[k])
                 + THR_W'(tolerance_i);
      s1_en[k]   = (rd_row_q.rad[k] != '0) && (job_q.atom.rad[k] != '0);
    end
  end

  // Stage four compare and order priority.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s4_within[k] = s4_en_q[k] &&
                     (s4_sum_q <= SUM_W'({s4_tsq_q[k], {TSQ_SHIFT{1'b0}}}));
    end
    if (s4_within[2]) begin
      s5_order_d = ORD_TRIPLE;
    end else if (s4_within[1]) begin
      s5_order_d = ORD_DOUBLE;
    end else if (s4_within[0]) begin
      s5_order_d = ORD_SINGLE;
    end else begin
      s5_order_d = ORD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q    <= issue && is_last_cmp;
    s1_earlier_q <= cmp_q;

    s2_last_q    <= s1_last_q;
    s2_earlier_q <= s1_earlier_q;
    s2_newer_q   <= job_q.idx;
    s2_en_q      <= s1_en;

    s3_last_q    <= s2_last_q;
    s3_earlier_q <= s2_earlier_q;
    s3_newer_q   <= s2_newer_q;
    s3_en_q      <= s2_en_q;

    s4_last_q    <= s3_last_q;
    s4_earlier_q <= s3_earlier_q;
    s4_newer_q   <= s3_newer_q;
    s4_en_q      <= s3_en_q;
    s4_sum_q     <= SUM_W'(s3_sq_q[0]) + SUM_W'(s3_sq_q[1]) + SUM_W'(s3_sq_q[2]);

    s5_last_q    <= s4_last_q;
    s5_earlier_q <= s4_earlier_q;
    s5_newer_q   <= s4_newer_q;
    s5_order_q   <= s5_order_d;

    for (int k = 0; k < 3; k++) begin
      s2_abs_q[k] <= s1_abs[k];
      s2_thr_q[k] <= s1_thr[k];
      s3_sq_q[k]  <= SQ_W'(s2_abs_q[k]) * SQ_W'(s2_abs_q[k]);
      s3_tsq_q[k] <= TSQ_W'(s2_thr_q[k]) * TSQ_W'(s2_thr_q[k]);
      s4_tsq_q[k] <= s3_tsq_q[k];
    end
  end

  // A found bond waits until the next bond or the end of the run decides its last flag.
  // The flush cycle always meets an empty slot, since a job start leaves one.
  assign bonded = s5_v_q && (s5_order_q != ORD_NONE);

  always_comb begin
    res_push_o = 1'b0;
    res_last   = 1'b0;
    pend_v_d   = pend_v_q;
    pend_load  = 1'b0;
    flush_d    = 1'b0;
    if (flush_q) begin
      res_push_o = 1'b1;
      res_last   = 1'b1;
      pend_v_d   = 1'b0;
    end else if (bonded) begin
      res_push_o = pend_v_q;
      pend_load  = 1'b1;
      pend_v_d   = 1'b1;
      flush_d    = s5_last_q;
    end else if (s5_v_q && s5_last_q) begin
      res_push_o = pend_v_q;
      res_last   = 1'b1;
      pend_v_d   = 1'b0;
    end
  end

  always_comb begin
    res_o.earlier = pend_earlier_q;
    res_o.newer   = pend_newer_q;
    res_o.order   = pend_order_q;
    res_o.last    = res_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      flush_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      flush_q  <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_load) begin
      pend_earlier_q <= IDX_W'(s5_earlier_q);
      pend_newer_q   <= s5_newer_q;
      pend_order_q   <= s5_order_q;
    end
  end

endmodule

// ===== hdl/pairwise_bond_order_detector_top.sv =====
// Top level of the pairwise bond order detector.
// Joins the front end, the job queue, the back end and the result queue.
// Depends on pbod_pkg, pbod_front, pbod_fifo and pbod_back.
//
// Atoms arrive one word at a time on the input channel; a word with first_atom set
// starts a new molecule. Each atom is compared with every stored atom of the molecule
// and one result word is sent per bonded pair, in order of rising stored index; the
// last result word for an atom carries last_of_run. Atoms beyond MAX_ATOMS are dropped.
// The user must write the tolerance register through cfg_we_i and cfg_wdata_i only
// while idle; the block itself does not enforce this. The back end takes each job in
// its idle state, then compares the atom with each stored atom in turn. A bond word
// is held in the back end until the next bond or the end of the compares marks it.
// A two-word job queue lets the input side accept while the back end is busy.
// Reset empties the store and both queues and sets the tolerance to 0.08 angstrom.
// When the receiver stalls, results collect in a 16-word queue; compares pause
// once it nears full, then the job queue fills and the input stalls.
module pairwise_bond_order_detector_top #(
  parameter int MAX_ATOMS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pbod_pkg::TOL_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              first_atom_i,
  input  logic signed [pbod_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [pbod_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [pbod_pkg::POS_W-1:0] pos_z_i,
  input  logic [pbod_pkg::RAD_W-1:0]        radius_single_i,
  input  logic [pbod_pkg::RAD_W-1:0]        radius_double_i,
  input  logic [pbod_pkg::RAD_W-1:0]        radius_triple_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pbod_pkg::IDX_W-1:0]        earlier_index_o,
  output logic [pbod_pkg::IDX_W-1:0]        newer_index_o,
  output logic [pbod_pkg::ORD_W-1:0]        order_o,
  output logic                              last_of_run_o
);

  import pbod_pkg::*;

  logic [TOL_W-1:0]     tol_q;
  logic                 job_push, job_pop, job_full, job_empty;
  logic [JOB_CNT_W-1:0] job_count;
  job_t                 job_in, job_head;
  logic                 res_push, out_pop, out_full, out_empty;
  result_t              res_in, out_head;
  logic [OUT_CNT_W-1:0] out_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  pbod_front #(
    .MAX_ATOMS(MAX_ATOMS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_atom_i   (first_atom_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .radius_single_i(radius_single_i),
    .radius_double_i(radius_double_i),
    .radius_triple_i(radius_triple_i),
    .job_full_i     (job_full),
    .job_push_o     (job_push),
    .job_o          (job_in)
  );

  pbod_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(JOB_DEPTH)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_in),
    .pop_i  (job_pop),
    .rdata_o(job_head),
    .empty_o(job_empty),
    .full_o (job_full),
    .count_o(job_count)
  );

  pbod_back #(
    .MAX_ATOMS(MAX_ATOMS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_i      (job_head),
    .job_pop_o  (job_pop),
    .tolerance_i(tol_q),
    .out_count_i(out_count),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  pbod_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .pop_i  (out_pop),
    .rdata_o(out_head),
    .empty_o(out_empty),
    .full_o (out_full),
    .count_o(out_count)
  );

  assign out_valid_o     = !out_empty;
  assign out_pop         = out_valid_o && !out_stall_i;
  assign earlier_index_o = out_head.earlier;
  assign newer_index_o   = out_head.newer;
  assign order_o         = out_head.order;
  assign last_of_run_o   = out_head.last;

  a_job_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(job_push && job_full))
    else $error("job queue written while full");

  a_job_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(job_pop && job_empty))
    else $error("job queue read while empty");

  a_job_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_count <= JOB_CNT_W'(JOB_DEPTH))
    else $error("job queue count out of range");

  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && out_full))
    else $error("result queue written while full");

endmodule
